// ===== sv/accel_lowpass_highpass_filter_defines.svh =====
// Assertion macros used by the filter module.
`ifndef ACCEL_LOWPASS_HIGHPASS_FILTER_DEFINES_SVH
`define ACCEL_LOWPASS_HIGHPASS_FILTER_DEFINES_SVH

`ifndef SYNTH
`define ALF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alf assertion failed");
`define ALF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alf assertion failed");
`else
`define ALF_ASSERT(name, prop)
`define ALF_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== sv/alf_pkg.sv =====
`default_nettype none

package alf_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 8;
  localparam int COEF_BITS     = 16;
  localparam int STATE_BITS    = SAMPLE_BITS + FRACTION_BITS;
  localparam int ROT_BITS      = SAMPLE_BITS + 1;
  localparam int DRIVE_BITS    = STATE_BITS + 1;
  localparam int DIFF_BITS     = STATE_BITS + 2;
  localparam int PROD_BITS     = COEF_BITS + 1 + DIFF_BITS;
  localparam int SUM_BITS      = PROD_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LANDSCAPE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_XY   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_ZL   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_ZH   = 2'd3;

  localparam logic [COEF_BITS-1:0] POLE_XY_RESET = 16'd63570;
  localparam logic [COEF_BITS-1:0] POLE_ZL_RESET = 16'd58982;
  localparam logic [COEF_BITS-1:0] POLE_ZH_RESET = 16'd49152;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ROT_BITS-1:0]    rot_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [DRIVE_BITS-1:0]  drive_t;
  typedef logic [COEF_BITS-1:0]          coef_t;

  typedef struct packed {
    logic  landscape;
    coef_t pole_xy;
    coef_t pole_zl;
    coef_t pole_zh;
  } cfg_t;

  typedef struct packed {
    logic   issue;
    coef_t  pole;
    state_t prev;
    drive_t drive;
  } mac_req_t;

endpackage

`default_nettype wire

// ===== sv/alf_in_if.sv =====
`default_nettype none

interface alf_in_if;
  logic             valid;
  logic             ready;
  alf_pkg::sample_t raw_x;
  alf_pkg::sample_t raw_y;
  alf_pkg::sample_t raw_z;

  modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

`default_nettype wire

// ===== sv/alf_out_if.sv =====
`default_nettype none

interface alf_out_if;
  logic            valid;
  logic            ready;
  alf_pkg::state_t x_filtered;
  alf_pkg::state_t y_filtered;
  alf_pkg::state_t z_lowpassed;
  alf_pkg::state_t z_highpassed;

  modport source (
    output valid, output x_filtered, output y_filtered,
    output z_lowpassed, output z_highpassed, input ready
  );
  modport sink (
    input valid, input x_filtered, input y_filtered,
    input z_lowpassed, input z_highpassed, output ready
  );
endinterface

`default_nettype wire

// ===== sv/alf_cfg.sv =====
`default_nettype none

module alf_cfg (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [alf_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  output alf_pkg::cfg_t                         cfg_o
);

  alf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.landscape <= 1'b1;
      cfg_q.pole_xy   <= alf_pkg::POLE_XY_RESET;
      cfg_q.pole_zl   <= alf_pkg::POLE_ZL_RESET;
      cfg_q.pole_zh   <= alf_pkg::POLE_ZH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        alf_pkg::CFG_LANDSCAPE: cfg_q.landscape <= cfg_data_i[0];
        alf_pkg::CFG_POLE_XY:   cfg_q.pole_xy   <= cfg_data_i[alf_pkg::COEF_BITS-1:0];
        alf_pkg::CFG_POLE_ZL:   cfg_q.pole_zl   <= cfg_data_i[alf_pkg::COEF_BITS-1:0];
        alf_pkg::CFG_POLE_ZH:   cfg_q.pole_zh   <= cfg_data_i[alf_pkg::COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/alf_mac.sv =====
`default_nettype none

module alf_mac (
  input  logic              clk_i,
  input  alf_pkg::mac_req_t req_i,
  output alf_pkg::state_t   result_o
);

  localparam int SHIFT_BITS = alf_pkg::SUM_BITS - alf_pkg::COEF_BITS;
  localparam logic signed [alf_pkg::SUM_BITS-1:0] RoundHalf =
    {{SHIFT_BITS{1'b0}}, 1'b1, {(alf_pkg::COEF_BITS-1){1'b0}}};

  logic signed [alf_pkg::DIFF_BITS-1:0]  diff;
  logic signed [alf_pkg::COEF_BITS:0]    pole_s;
  logic signed [alf_pkg::PROD_BITS-1:0]  prod_d;
  logic signed [alf_pkg::PROD_BITS-1:0]  prod_q;
  alf_pkg::drive_t                       drive_q;
  logic signed [alf_pkg::SUM_BITS-1:0]   sum;
  logic signed [SHIFT_BITS-1:0]          shifted;
  logic                                  overflow;

  // The section sum is rewritten as drive * ONE + pole * (prev - drive).
  assign diff   = alf_pkg::DIFF_BITS'($signed(req_i.prev)) -
                  alf_pkg::DIFF_BITS'($signed(req_i.drive));
  assign pole_s = $signed({1'b0, req_i.pole});
  assign prod_d = alf_pkg::PROD_BITS'(pole_s) * alf_pkg::PROD_BITS'(diff);

  always_ff @(posedge clk_i) begin
    if (req_i.issue) begin
      prod_q  <= prod_d;
      drive_q <= req_i.drive;
    end
  end

  assign sum = alf_pkg::SUM_BITS'(prod_q) +
               (alf_pkg::SUM_BITS'(drive_q) <<< alf_pkg::COEF_BITS) + RoundHalf;
  assign shifted  = sum[alf_pkg::SUM_BITS-1:alf_pkg::COEF_BITS];
  assign overflow = !((&shifted[SHIFT_BITS-1:alf_pkg::STATE_BITS-1]) ||
                      !(|shifted[SHIFT_BITS-1:alf_pkg::STATE_BITS-1]));

  always_comb begin
    if (!overflow) begin
      result_o = shifted[alf_pkg::STATE_BITS-1:0];
    end else if (shifted[SHIFT_BITS-1]) begin
      result_o = {1'b1, {(alf_pkg::STATE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(alf_pkg::STATE_BITS-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ===== sv/accel_lowpass_highpass_filter.sv =====
// Three-axis accelerometer filter: X and Y lowpass, Z lowpass then highpass.
// An item on the sample_i channel carries one signed sample per axis; it is
// accepted at a rising edge with valid and ready both high. In landscape mode
// the axes are rotated before filtering.
// The four filter sections run one after another through a single shared
// multiplier with a product register, so an item passes in order through the
// steps X, Y, Zl, ZlRet, Zh and Out after acceptance. Its result is valid on
// result_o once step Out loads it into the output register; sample_i.ready
// is low from acceptance until then, so the block takes no new item until it
// is through with the last one. The multiplier and the dependency of the Z
// highpass on the fresh Z lowpass value set this.
// The output register holds one finished item; if the receiver stalls while
// it is still full, the block waits in its last step with the item's last
// section pending and loads it once the register frees.
// Configuration writes take effect at once; the user makes them while idle,
// which the block does not enforce. Reset clears all filter state to zero,
// empties the output register and restores default poles and landscape mode.
`default_nettype none

`include "accel_lowpass_highpass_filter_defines.svh"

module accel_lowpass_highpass_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [alf_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  alf_in_if.sink                            sample_i,
  alf_out_if.source                         result_o
);

  localparam int STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] StepX     = 3'd0;
  localparam logic [STEP_BITS-1:0] StepY     = 3'd1;
  localparam logic [STEP_BITS-1:0] StepZl    = 3'd2;
  localparam logic [STEP_BITS-1:0] StepZlRet = 3'd3;
  localparam logic [STEP_BITS-1:0] StepZh    = 3'd4;
  localparam logic [STEP_BITS-1:0] StepOut   = 3'd5;

  alf_pkg::cfg_t     cfg;
  alf_pkg::mac_req_t mac_req;
  alf_pkg::state_t   mac_res;

  logic                 busy_q;
  logic [STEP_BITS-1:0] step_q;
  logic                 accept;
  logic                 finish;
  logic                 out_valid_q;
  logic                 out_valid_d;

  alf_pkg::rot_t    ax_q;
  alf_pkg::rot_t    ay_q;
  alf_pkg::sample_t az_q;
  alf_pkg::state_t  x_acc_q;
  alf_pkg::state_t  y_acc_q;
  alf_pkg::state_t  zl_acc_q;
  alf_pkg::state_t  zh_acc_q;
  alf_pkg::state_t  zl_old_q;
  alf_pkg::state_t  out_x_q;
  alf_pkg::state_t  out_y_q;
  alf_pkg::state_t  out_zl_q;
  alf_pkg::state_t  out_zh_q;

  alf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  alf_mac u_mac (
    .clk_i    (clk_i),
    .req_i    (mac_req),
    .result_o (mac_res)
  );

  assign sample_i.ready = !busy_q;
  assign accept = sample_i.valid && !busy_q;
  assign finish = busy_q && (step_q == StepOut) && (!out_valid_q || result_o.ready);

  always_comb begin
    mac_req.issue = 1'b0;
    mac_req.pole  = '0;
    mac_req.prev  = '0;
    mac_req.drive = '0;
    if (busy_q) begin
      unique case (step_q)
        StepX: begin
          mac_req.issue = 1'b1;
          mac_req.pole  = cfg.pole_xy;
          mac_req.prev  = x_acc_q;
          mac_req.drive = alf_pkg::DRIVE_BITS'(ax_q) <<< alf_pkg::FRACTION_BITS;
        end
        StepY: begin
          mac_req.issue = 1'b1;
          mac_req.pole  = cfg.pole_xy;
          mac_req.prev  = y_acc_q;
          mac_req.drive = alf_pkg::DRIVE_BITS'(ay_q) <<< alf_pkg::FRACTION_BITS;
        end
        StepZl: begin
          mac_req.issue = 1'b1;
          mac_req.pole  = cfg.pole_zl;
          mac_req.prev  = zl_acc_q;
          mac_req.drive = alf_pkg::DRIVE_BITS'(az_q) <<< alf_pkg::FRACTION_BITS;
        end
        StepZh: begin
          mac_req.issue = 1'b1;
          mac_req.pole  = cfg.pole_zh;
          mac_req.prev  = zh_acc_q;
          mac_req.drive = alf_pkg::DRIVE_BITS'(zl_acc_q) -
                          alf_pkg::DRIVE_BITS'(zl_old_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= StepX;
      x_acc_q  <= '0;
      y_acc_q  <= '0;
      zl_acc_q <= '0;
      zh_acc_q <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= StepX;
    end else if (busy_q) begin
      if (step_q == StepOut) begin
        if (finish) begin
          busy_q   <= 1'b0;
          zh_acc_q <= mac_res;
        end
      end else begin
        step_q <= step_q + STEP_BITS'(1);
        if (step_q == StepY) begin
          x_acc_q <= mac_res;
        end
        if (step_q == StepZl) begin
          y_acc_q <= mac_res;
        end
        if (step_q == StepZlRet) begin
          zl_acc_q <= mac_res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cfg.landscape) begin
        ax_q <= -alf_pkg::ROT_BITS'(sample_i.raw_y);
        ay_q <= alf_pkg::ROT_BITS'(sample_i.raw_x);
      end else begin
        ax_q <= alf_pkg::ROT_BITS'(sample_i.raw_x);
        ay_q <= alf_pkg::ROT_BITS'(sample_i.raw_y);
      end
      az_q <= sample_i.raw_z;
    end
    if (busy_q && (step_q == StepZlRet)) begin
      zl_old_q <= zl_acc_q;
    end
    if (finish) begin
      out_x_q  <= x_acc_q;
      out_y_q  <= y_acc_q;
      out_zl_q <= zl_acc_q;
      out_zh_q <= mac_res;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.x_filtered   = out_x_q;
  assign result_o.y_filtered   = out_y_q;
  assign result_o.z_lowpassed  = out_zl_q;
  assign result_o.z_highpassed = out_zh_q;

  `ALF_ASSERT_NEXT(a_accept_starts, accept, busy_q && (step_q == StepX))
  `ALF_ASSERT_NEXT(a_step_advances, busy_q && (step_q != StepOut),
                   busy_q && (step_q == $past(step_q) + STEP_BITS'(1)))
  `ALF_ASSERT(a_result_from_last_step,
              $rose(out_valid_q) |-> ($past(busy_q) && ($past(step_q) == StepOut)))
  `ALF_ASSERT(a_no_issue_when_idle, mac_req.issue |-> busy_q)

endmodule

`default_nettype wire
